// ===== src/ils_pkg.sv =====
// Shared types and codes for the indexed list store.
// Item structs, operation and status codes, sequencer states, default sizes.
// No dependencies.
`default_nettype none

package ils_pkg;

	localparam int unsigned CAPACITY_DEF    = 1024;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam int unsigned OP_W      = 3;
	localparam int unsigned POS_W     = 11;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned CNT_OUT_W = 11;

	localparam logic [OP_W-1:0] OP_GET      = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
	localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] new_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [STATUS_W-1:0]      status;
		logic [CNT_OUT_W-1:0]     entry_count;
	} out_item_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_ALLOC,
		S_VREAD,
		S_FIX_RD,
		S_FIX_WR,
		S_RESP
	} seq_state_t;

endpackage

`default_nettype wire

// ===== src/indexed_list_store.sv =====
// Top level of the indexed list store: a doubly linked list of values held
// in a link RAM and a value RAM, run by one sequencer.
// Depends on ils_pkg, ils_ram and ils_seq.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------
//   req     | in  | req_valid, req_stall | operation, position, new_value
//   rsp     | out | rsp_valid, rsp_stall | read_value, status, entry_count
//
// One item at a time; the walk follows the link RAM one slot per cycle.
// After reset a clearing pass threads every slot onto the free chain;
// req_stall stays high until it ends. While rsp is stalled on a result, the
// next result waits in the sequencer and req_stall stays high.
`default_nettype none

module indexed_list_store #(
	parameter int unsigned CAPACITY    = ils_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  ils_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ils_pkg::out_item_t rsp
);

	import ils_pkg::*;

	localparam int unsigned SW = $clog2(CAPACITY);
	localparam int unsigned LW = 2 * SW;

	logic                   lk_we;
	logic [SW-1:0]          lk_waddr;
	logic [LW-1:0]          lk_wdata;
	logic [SW-1:0]          lk_raddr;
	logic [LW-1:0]          lk_rdata;
	logic                   vl_we;
	logic [SW-1:0]          vl_waddr;
	logic [VALUE_WIDTH-1:0] vl_wdata;
	logic [SW-1:0]          vl_raddr;
	logic [VALUE_WIDTH-1:0] vl_rdata;

	ils_seq #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.lk_we     (lk_we),
		.lk_waddr  (lk_waddr),
		.lk_wdata  (lk_wdata),
		.lk_raddr  (lk_raddr),
		.lk_rdata  (lk_rdata),
		.vl_we     (vl_we),
		.vl_waddr  (vl_waddr),
		.vl_wdata  (vl_wdata),
		.vl_raddr  (vl_raddr),
		.vl_rdata  (vl_rdata)
	);

	// link word: {next, prev}
	ils_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (LW)
	) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	ils_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_WIDTH)
	) u_value_ram (
		.clk   (clk),
		.we    (vl_we),
		.waddr (vl_waddr),
		.wdata (vl_wdata),
		.raddr (vl_raddr),
		.rdata (vl_rdata)
	);

endmodule

`default_nettype wire

// ===== src/ils_ram.sv =====
// Simple dual-port synchronous RAM: one write and one read per cycle.
// Read data is registered, old data on a same-address clash.
// No dependencies.
`default_nettype none

module ils_ram #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned WIDTH = 1,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

`default_nettype wire

// ===== src/ils_seq.sv =====
// Sequencer for the indexed list store: walks the link chain, allocates and
// frees slots and patches neighbour links by read-modify-write.
// Depends on ils_pkg; drives the link and value RAM ports.
`default_nettype none

module ils_seq #(
	parameter int unsigned CAPACITY    = ils_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF,
	localparam int unsigned SW         = $clog2(CAPACITY),
	localparam int unsigned LW         = 2 * SW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  ils_pkg::in_item_t      req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output ils_pkg::out_item_t     rsp,
	output logic                   lk_we,
	output logic [SW-1:0]          lk_waddr,
	output logic [LW-1:0]          lk_wdata,
	output logic [SW-1:0]          lk_raddr,
	input  logic [LW-1:0]          lk_rdata,
	output logic                   vl_we,
	output logic [SW-1:0]          vl_waddr,
	output logic [VALUE_WIDTH-1:0] vl_wdata,
	output logic [SW-1:0]          vl_raddr,
	input  logic [VALUE_WIDTH-1:0] vl_rdata
);

	import ils_pkg::*;

	localparam int unsigned CW    = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;
	localparam int unsigned VW    = VALUE_WIDTH;

	typedef enum logic [2:0] {K_GET, K_HEAD, K_TAIL, K_MID, K_DEL} kind_t;

	seq_state_t state_q, state_d;
	kind_t kind_q, kind_d;

	logic [SW-1:0] clr_q, clr_d;
	logic [SW-1:0] head_q, head_d;
	logic [SW-1:0] tail_q, tail_d;
	logic [SW-1:0] free_q, free_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] cur_q, cur_d;
	logic [POS_W-1:0] rem_q, rem_d;
	logic [VW-1:0] val_q, val_d;
	logic [SW-1:0] nx_q, nx_d;
	logic [SW-1:0] pv_q, pv_d;

	// pending link patches: a is worked first, b follows if valid
	logic [SW-1:0] fa_addr_q, fa_addr_d;
	logic          fa_is_next_q, fa_is_next_d;
	logic [SW-1:0] fa_val_q, fa_val_d;
	logic          fb_valid_q, fb_valid_d;
	logic [SW-1:0] fb_addr_q, fb_addr_d;
	logic          fb_is_next_q, fb_is_next_d;
	logic [SW-1:0] fb_val_q, fb_val_d;

	logic [DATA_W-1:0]   res_rd_q, res_rd_d;
	logic [STATUS_W-1:0] res_st_q, res_st_d;

	logic      rsp_valid_q;
	out_item_t rsp_q;
	logic      rsp_load;

	logic [SW-1:0]    lk_next, lk_prev;
	logic [CMP_W-1:0] pos_x, cnt_x;
	logic             full, empty;

	assign lk_next = lk_rdata[LW-1:SW];
	assign lk_prev = lk_rdata[SW-1:0];
	assign pos_x   = CMP_W'(req.position);
	assign cnt_x   = CMP_W'(cnt_q);
	assign full    = (cnt_q == CW'(CAPACITY));
	assign empty   = (cnt_q == '0);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		clr_d        = clr_q;
		head_d       = head_q;
		tail_d       = tail_q;
		free_d       = free_q;
		cnt_d        = cnt_q;
		cur_d        = cur_q;
		rem_d        = rem_q;
		val_d        = val_q;
		nx_d         = nx_q;
		pv_d         = pv_q;
		fa_addr_d    = fa_addr_q;
		fa_is_next_d = fa_is_next_q;
		fa_val_d     = fa_val_q;
		fb_valid_d   = fb_valid_q;
		fb_addr_d    = fb_addr_q;
		fb_is_next_d = fb_is_next_q;
		fb_val_d     = fb_val_q;
		res_rd_d     = res_rd_q;
		res_st_d     = res_st_q;
		rsp_load     = 1'b0;
		lk_we        = 1'b0;
		lk_waddr     = cur_q;
		lk_wdata     = {cur_q, cur_q};
		lk_raddr     = cur_q;
		vl_we        = 1'b0;
		vl_waddr     = free_q;
		vl_wdata     = val_q;
		vl_raddr     = cur_q;

		unique case (state_q)
			S_CLEAR: begin
				// thread every slot onto the free chain, last one back to slot 0
				lk_we    = 1'b1;
				lk_waddr = clr_q;
				if (clr_q == SW'(CAPACITY - 1)) begin
					lk_wdata = {{SW{1'b0}}, {SW{1'b0}}};
					state_d  = S_IDLE;
				end else begin
					lk_wdata = {clr_q + SW'(1), {SW{1'b0}}};
					clr_d    = clr_q + SW'(1);
				end
			end

			S_IDLE: begin
				if (req_valid) begin
					val_d    = VW'(64'($signed(req.new_value)));
					rem_d    = req.position;
					res_rd_d = '1;
					res_st_d = STAT_DONE;
					unique case (req.operation)
						OP_GET: begin
							if (pos_x >= cnt_x) begin
								res_st_d = STAT_RANGE;
								state_d  = S_RESP;
							end else begin
								kind_d   = K_GET;
								cur_d    = head_q;
								lk_raddr = head_q;
								state_d  = S_WALK;
							end
						end
						OP_INS_HEAD, OP_INS_TAIL: begin
							if (full) begin
								res_st_d = STAT_FULL;
								state_d  = S_RESP;
							end else begin
								kind_d   = (req.operation == OP_INS_HEAD) ? K_HEAD : K_TAIL;
								lk_raddr = free_q;
								state_d  = S_ALLOC;
							end
						end
						OP_INS_AT: begin
							priority if (pos_x > cnt_x) begin
								res_st_d = STAT_RANGE;
								state_d  = S_RESP;
							end else if (full) begin
								res_st_d = STAT_FULL;
								state_d  = S_RESP;
							end else if (pos_x == cnt_x) begin
								kind_d   = K_TAIL;
								lk_raddr = free_q;
								state_d  = S_ALLOC;
							end else if (req.position == '0) begin
								kind_d   = K_HEAD;
								lk_raddr = free_q;
								state_d  = S_ALLOC;
							end else begin
								kind_d   = K_MID;
								cur_d    = head_q;
								lk_raddr = head_q;
								state_d  = S_WALK;
							end
						end
						OP_DELETE: begin
							if (pos_x >= cnt_x) begin
								res_st_d = STAT_RANGE;
								state_d  = S_RESP;
							end else begin
								kind_d   = K_DEL;
								cur_d    = head_q;
								lk_raddr = head_q;
								state_d  = S_WALK;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end

			S_WALK: begin
				// lk_rdata holds the link word of cur_q
				if (rem_q != '0) begin
					cur_d    = lk_next;
					lk_raddr = lk_next;
					rem_d    = rem_q - POS_W'(1);
				end else begin
					unique case (kind_q)
						K_GET: begin
							vl_raddr = cur_q;
							state_d  = S_VREAD;
						end
						K_MID: begin
							nx_d     = cur_q;
							pv_d     = lk_prev;
							lk_raddr = free_q;
							state_d  = S_ALLOC;
						end
						K_DEL: begin
							// unlinked slot goes to the front of the free chain
							lk_we    = 1'b1;
							lk_waddr = cur_q;
							lk_wdata = {free_q, lk_prev};
							free_d   = cur_q;
							cnt_d    = cnt_q - CW'(1);
							priority if (cnt_q == CW'(1)) begin
								head_d  = '0;
								tail_d  = '0;
								state_d = S_RESP;
							end else if (cur_q == head_q) begin
								head_d       = lk_next;
								fa_addr_d    = lk_next;
								fa_is_next_d = 1'b0;
								fa_val_d     = lk_next;
								state_d      = S_FIX_RD;
							end else if (cur_q == tail_q) begin
								tail_d       = lk_prev;
								fa_addr_d    = lk_prev;
								fa_is_next_d = 1'b1;
								fa_val_d     = lk_prev;
								state_d      = S_FIX_RD;
							end else begin
								fa_addr_d    = lk_prev;
								fa_is_next_d = 1'b1;
								fa_val_d     = lk_next;
								fb_valid_d   = 1'b1;
								fb_addr_d    = lk_next;
								fb_is_next_d = 1'b0;
								fb_val_d     = lk_prev;
								state_d      = S_FIX_RD;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end

			S_ALLOC: begin
				// lk_rdata holds the link word of the free slot
				free_d   = lk_next;
				vl_we    = 1'b1;
				vl_waddr = free_q;
				vl_wdata = val_q;
				lk_we    = 1'b1;
				lk_waddr = free_q;
				cnt_d    = cnt_q + CW'(1);
				unique case (kind_q)
					K_HEAD: begin
						lk_wdata = {(empty ? free_q : head_q), free_q};
						head_d   = free_q;
						if (empty) begin
							tail_d  = free_q;
							state_d = S_RESP;
						end else begin
							fa_addr_d    = head_q;
							fa_is_next_d = 1'b0;
							fa_val_d     = free_q;
							state_d      = S_FIX_RD;
						end
					end
					K_TAIL: begin
						lk_wdata = {free_q, (empty ? free_q : tail_q)};
						tail_d   = free_q;
						if (empty) begin
							head_d  = free_q;
							state_d = S_RESP;
						end else begin
							fa_addr_d    = tail_q;
							fa_is_next_d = 1'b1;
							fa_val_d     = free_q;
							state_d      = S_FIX_RD;
						end
					end
					K_MID: begin
						lk_wdata     = {nx_q, pv_q};
						fa_addr_d    = pv_q;
						fa_is_next_d = 1'b1;
						fa_val_d     = free_q;
						fb_valid_d   = 1'b1;
						fb_addr_d    = nx_q;
						fb_is_next_d = 1'b0;
						fb_val_d     = free_q;
						state_d      = S_FIX_RD;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end

			S_FIX_RD: begin
				lk_raddr = fa_addr_q;
				state_d  = S_FIX_WR;
			end

			S_FIX_WR: begin
				lk_we    = 1'b1;
				lk_waddr = fa_addr_q;
				lk_wdata = fa_is_next_q ? {fa_val_q, lk_prev} : {lk_next, fa_val_q};
				if (fb_valid_q) begin
					fa_addr_d    = fb_addr_q;
					fa_is_next_d = fb_is_next_q;
					fa_val_d     = fb_val_q;
					fb_valid_d   = 1'b0;
					state_d      = S_FIX_RD;
				end else begin
					state_d = S_RESP;
				end
			end

			S_VREAD: begin
				res_rd_d = DATA_W'(64'($signed(vl_rdata)));
				state_d  = S_RESP;
			end

			S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			free_q      <= '0;
			cnt_q       <= '0;
			fb_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			free_q     <= free_d;
			cnt_q      <= cnt_d;
			fb_valid_q <= fb_valid_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q       <= kind_d;
		cur_q        <= cur_d;
		rem_q        <= rem_d;
		val_q        <= val_d;
		nx_q         <= nx_d;
		pv_q         <= pv_d;
		fa_addr_q    <= fa_addr_d;
		fa_is_next_q <= fa_is_next_d;
		fa_val_q     <= fa_val_d;
		fb_addr_q    <= fb_addr_d;
		fb_is_next_q <= fb_is_next_d;
		fb_val_q     <= fb_val_d;
		res_rd_q     <= res_rd_d;
		res_st_q     <= res_st_d;
		if (rsp_load) begin
			rsp_q.read_value  <= res_rd_q;
			rsp_q.status      <= res_st_q;
			rsp_q.entry_count <= CNT_OUT_W'(cnt_q);
		end
	end

endmodule

`default_nettype wire
